// ----- rtl/ernn_pkg.sv -----
// ============================================================================
// ernn_pkg
// Shared sizes, request codes, controller command types and the sigmoid table
// of the recurrent cell.
// ============================================================================
package ernn_pkg;

    localparam int IN_SIZE     = 8;
    localparam int HID_SIZE    = 8;
    localparam int OUT_SIZE    = 4;
    localparam int MAX_RESULTS = 8;

    localparam int IN_W  = (IN_SIZE  > 1) ? $clog2(IN_SIZE)  : 1;
    localparam int HID_W = (HID_SIZE > 1) ? $clog2(HID_SIZE) : 1;
    localparam int OUT_W = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam int ROW_W = (HID_W > OUT_W) ? HID_W : OUT_W;
    localparam int COL_W = (HID_W > IN_W) ? HID_W : IN_W;

    localparam int OUT_EMIT = (OUT_SIZE < MAX_RESULTS) ? OUT_SIZE : MAX_RESULTS;
    localparam int HID_EMIT = (HID_SIZE < MAX_RESULTS) ? HID_SIZE : MAX_RESULTS;

    localparam int ACC_W = 40;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_ELEM  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [2:0] GRP_IH = 3'd0;
    localparam logic [2:0] GRP_HH = 3'd1;
    localparam logic [2:0] GRP_IO = 3'd2;
    localparam logic [2:0] GRP_HO = 3'd3;
    localparam logic [2:0] GRP_BO = 3'd4;
    localparam logic [2:0] GRP_BH = 3'd5;

    typedef struct packed {
        logic             acc_init;
        logic             mac_en;
        logic             mac_hid;
        logic [COL_W-1:0] col;
        logic             layer_hid;
        logic [ROW_W-1:0] row;
        logic             emit_out;
        logic             emit_last;
        logic             store_h;
        logic             commit_h;
        logic             clear_h;
        logic             read_h;
        logic [HID_W-1:0] read_idx;
    } ernn_cmd_t;

    function automatic logic [15:0] sig_pos(input int k);
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        longint unsigned quo;
        longint unsigned rem;
        e = 64'd1 << 30;
        for (int i = 0; i < k; i++)
            e = (e * 64'd1008687095 + (64'd1 << 29)) >> 30;
        den = (64'd1 << 30) + e;
        num = (64'd4096 << 30) + (den >> 1);
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | 64'(num[b]);
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return 16'(quo);
    endfunction

    function automatic logic [15:0] sig_entry(input int i);
        int k;
        k = i - 128;
        if (k >= 0)
            return sig_pos(k);
        return 16'(16'd4096 - sig_pos(-k));
    endfunction

    typedef logic [15:0] sig_tab_t [256];

    function automatic sig_tab_t build_sig();
        sig_tab_t t;
        for (int i = 0; i < 256; i++)
            t[i] = sig_entry(i);
        return t;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig();

endpackage

// ----- rtl/ernn_ram.sv -----
// ============================================================================
// ernn_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module ernn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/ernn_ctrl.sv -----
// ============================================================================
// ernn_ctrl
// Sequencer of the cell: walks the output rows and then the hidden rows,
// one multiply-accumulate per cycle, walks the hidden vector for reads and clears it.
// ============================================================================
module ernn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         req_type,
    input  logic               elem_last,
    output logic               busy,
    output ernn_pkg::ernn_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_DRN1 = 3'd2;
    localparam logic [2:0] S_DRN2 = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_READ = 3'd5;
    localparam logic [2:0] S_COMM = 3'd6;

    localparam int COLS = ernn_pkg::IN_SIZE + ernn_pkg::HID_SIZE;
    localparam int CW   = $clog2(COLS);

    logic [2:0]                  state_reg, state_next;
    logic [CW-1:0]               j_reg, j_next;
    logic [ernn_pkg::ROW_W-1:0]  row_reg, row_next;
    logic                        hid_reg, hid_next;
    logic [ernn_pkg::HID_W-1:0]  rd_reg, rd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            row_reg   <= '0;
            hid_reg   <= 1'b0;
            rd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            row_reg   <= row_next;
            hid_reg   <= hid_next;
            rd_reg    <= rd_next;
        end
    end

    logic last_row;
    assign last_row = hid_reg ? (32'(row_reg) == ernn_pkg::HID_SIZE - 1)
                              : (32'(row_reg) == ernn_pkg::OUT_SIZE - 1);

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        row_next   = row_reg;
        hid_next   = hid_reg;
        rd_next    = rd_reg;
        cmd        = '0;
        cmd.row       = row_reg;
        cmd.layer_hid = hid_reg;
        cmd.read_idx  = rd_reg;
        if (32'(j_reg) < ernn_pkg::IN_SIZE)
        begin
            cmd.col     = ernn_pkg::COL_W'(j_reg);
            cmd.mac_hid = 1'b0;
        end
        else
        begin
            cmd.col     = ernn_pkg::COL_W'(32'(j_reg) - ernn_pkg::IN_SIZE);
            cmd.mac_hid = 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == ernn_pkg::REQ_ELEM && elem_last)
                    begin
                        state_next = S_MAC;
                        j_next     = '0;
                        row_next   = '0;
                        hid_next   = 1'b0;
                    end
                    else if (req_type == ernn_pkg::REQ_READ)
                    begin
                        state_next = S_READ;
                        rd_next    = '0;
                    end
                    else if (req_type == ernn_pkg::REQ_CLEAR)
                    begin
                        cmd.clear_h = 1'b1;
                    end
                end
            end
            S_MAC:
            begin
                cmd.mac_en   = 1'b1;
                cmd.acc_init = (j_reg == '0);
                if (32'(j_reg) == COLS - 1)
                begin
                    state_next = S_DRN1;
                end
                else
                begin
                    j_next = CW'(32'(j_reg) + 1);
                end
            end
            S_DRN1:
            begin
                state_next = S_DRN2;
            end
            S_DRN2:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (hid_reg)
                begin
                    cmd.store_h = 1'b1;
                end
                else if (32'(row_reg) < ernn_pkg::MAX_RESULTS)
                begin
                    cmd.emit_out  = 1'b1;
                    cmd.emit_last = last_row
                        || (32'(row_reg) == ernn_pkg::MAX_RESULTS - 1);
                end
                j_next = '0;
                if (last_row)
                begin
                    row_next = '0;
                    if (hid_reg)
                    begin
                        state_next = S_COMM;
                    end
                    else
                    begin
                        hid_next   = 1'b1;
                        state_next = S_MAC;
                    end
                end
                else
                begin
                    row_next   = ernn_pkg::ROW_W'(32'(row_reg) + 1);
                    state_next = S_MAC;
                end
            end
            S_COMM:
            begin
                cmd.commit_h = 1'b1;
                state_next   = S_IDLE;
            end
            S_READ:
            begin
                cmd.read_h    = 1'b1;
                cmd.emit_last = (32'(rd_reg) == ernn_pkg::HID_EMIT - 1);
                if (32'(rd_reg) == ernn_pkg::HID_EMIT - 1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_next = ernn_pkg::HID_W'(32'(rd_reg) + 1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- rtl/ernn_dp.sv -----
// ============================================================================
// ernn_dp
// Datapath of the cell: weight memories, input buffer, hidden vector,
// one shared multiply-accumulate unit, rounding, saturation and sigmoid.
// ============================================================================
module ernn_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_en,
    input  logic [1:0]          req_type,
    input  logic [2:0]          weight_group,
    input  logic [3:0]          row,
    input  logic [3:0]          col,
    input  logic signed [15:0]  value,
    input  ernn_pkg::ernn_cmd_t cmd,
    output logic                result_valid,
    output logic                result_kind,
    output logic [3:0]          result_index,
    output logic signed [15:0]  result_value,
    output logic                result_last
);

    localparam int IH_D = ernn_pkg::HID_SIZE * 16;
    localparam int HH_D = ernn_pkg::HID_SIZE * 16;
    localparam int IO_D = ernn_pkg::OUT_SIZE * 16;
    localparam int HO_D = ernn_pkg::OUT_SIZE * 16;
    localparam int BO_D = 16;
    localparam int BH_D = 16;

    logic is_load, wr_ih, wr_hh, wr_io, wr_ho, wr_bo, wr_bh;
    assign is_load = load_en && req_type == ernn_pkg::REQ_LOAD;
    assign wr_ih = is_load && weight_group == ernn_pkg::GRP_IH
        && 32'(row) < ernn_pkg::HID_SIZE && 32'(col) < ernn_pkg::IN_SIZE;
    assign wr_hh = is_load && weight_group == ernn_pkg::GRP_HH
        && 32'(row) < ernn_pkg::HID_SIZE && 32'(col) < ernn_pkg::HID_SIZE;
    assign wr_io = is_load && weight_group == ernn_pkg::GRP_IO
        && 32'(row) < ernn_pkg::OUT_SIZE && 32'(col) < ernn_pkg::IN_SIZE;
    assign wr_ho = is_load && weight_group == ernn_pkg::GRP_HO
        && 32'(row) < ernn_pkg::OUT_SIZE && 32'(col) < ernn_pkg::HID_SIZE;
    assign wr_bo = is_load && weight_group == ernn_pkg::GRP_BO
        && 32'(row) < ernn_pkg::OUT_SIZE;
    assign wr_bh = is_load && weight_group == ernn_pkg::GRP_BH
        && 32'(row) < ernn_pkg::HID_SIZE;

    logic [7:0] waddr, raddr;
    assign waddr = {row, col};
    assign raddr = {4'(cmd.row), 4'(cmd.col)};

    logic [15:0] q_ih, q_hh, q_io, q_ho, q_bo, q_bh;

    ernn_ram #(.WIDTH(16), .DEPTH(IH_D)) u_ih (.clk(clk), .we(wr_ih),
        .waddr($clog2(IH_D)'(waddr)), .wdata(value),
        .raddr($clog2(IH_D)'(raddr)), .rdata(q_ih));
    ernn_ram #(.WIDTH(16), .DEPTH(HH_D)) u_hh (.clk(clk), .we(wr_hh),
        .waddr($clog2(HH_D)'(waddr)), .wdata(value),
        .raddr($clog2(HH_D)'(raddr)), .rdata(q_hh));
    ernn_ram #(.WIDTH(16), .DEPTH(IO_D)) u_io (.clk(clk), .we(wr_io),
        .waddr($clog2(IO_D)'(waddr)), .wdata(value),
        .raddr($clog2(IO_D)'(raddr)), .rdata(q_io));
    ernn_ram #(.WIDTH(16), .DEPTH(HO_D)) u_ho (.clk(clk), .we(wr_ho),
        .waddr($clog2(HO_D)'(waddr)), .wdata(value),
        .raddr($clog2(HO_D)'(raddr)), .rdata(q_ho));
    ernn_ram #(.WIDTH(16), .DEPTH(BO_D)) u_bo (.clk(clk), .we(wr_bo),
        .waddr(row), .wdata(value), .raddr(4'(cmd.row)), .rdata(q_bo));
    ernn_ram #(.WIDTH(16), .DEPTH(BH_D)) u_bh (.clk(clk), .we(wr_bh),
        .waddr(row), .wdata(value), .raddr(4'(cmd.row)), .rdata(q_bh));

    logic [15:0] xbuf_reg [ernn_pkg::IN_SIZE];
    logic [15:0] h_reg    [ernn_pkg::HID_SIZE];
    logic [15:0] hn_reg   [ernn_pkg::HID_SIZE];

    always_ff @(posedge clk)
    begin
        if (load_en && req_type == ernn_pkg::REQ_ELEM && 32'(col) < ernn_pkg::IN_SIZE)
        begin
            xbuf_reg[ernn_pkg::IN_W'(col)] <= value;
        end
    end

    // Pipeline stages: address, memory and operand, product, accumulate.
    logic                  v1_reg, init1_reg, hid1_reg, lay1_reg;
    logic signed [15:0]    opa1_reg;
    logic                  v2_reg, init2_reg;
    logic signed [31:0]    prod2_reg;
    logic signed [15:0]    bias2_reg;
    logic signed [ernn_pkg::ACC_W-1:0] acc_reg;

    logic signed [15:0] opb1;
    assign opb1 = lay1_reg ? (hid1_reg ? q_hh : q_ih) : (hid1_reg ? q_ho : q_io);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_en;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        init1_reg <= cmd.acc_init;
        hid1_reg  <= cmd.mac_hid;
        lay1_reg  <= cmd.layer_hid;
        opa1_reg  <= cmd.mac_hid ? h_reg[ernn_pkg::HID_W'(cmd.col)]
                                 : xbuf_reg[ernn_pkg::IN_W'(cmd.col)];
        init2_reg <= init1_reg;
        prod2_reg <= opa1_reg * opb1;
        bias2_reg <= lay1_reg ? q_bh : q_bo;
        if (v2_reg)
        begin
            if (init2_reg)
                acc_reg <= ernn_pkg::ACC_W'({{(ernn_pkg::ACC_W-28){bias2_reg[15]}},
                           bias2_reg, 12'd0}) + ernn_pkg::ACC_W'(prod2_reg);
            else
                acc_reg <= acc_reg + ernn_pkg::ACC_W'(prod2_reg);
        end
    end

    logic signed [ernn_pkg::ACC_W-1:0] rnd;
    logic signed [ernn_pkg::ACC_W-13:0] sh;
    logic signed [15:0] sat;
    assign rnd = acc_reg + ernn_pkg::ACC_W'(2048);
    assign sh  = rnd[ernn_pkg::ACC_W-1:12];
    always_comb
    begin
        if (sh > $signed((ernn_pkg::ACC_W-12)'(32767)))
            sat = 16'sd32767;
        else if (sh < -$signed((ernn_pkg::ACC_W-12)'(32768)))
            sat = -16'sd32768;
        else
            sat = sh[15:0];
    end

    logic [7:0] bin;
    assign bin = 8'(({~sat[15], sat[14:0]}) >> 8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ernn_pkg::HID_SIZE; i++)
                h_reg[i] <= '0;
        end
        else if (cmd.clear_h)
        begin
            for (int i = 0; i < ernn_pkg::HID_SIZE; i++)
                h_reg[i] <= '0;
        end
        else if (cmd.commit_h)
        begin
            for (int i = 0; i < ernn_pkg::HID_SIZE; i++)
                h_reg[i] <= hn_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_h)
            hn_reg[ernn_pkg::HID_W'(cmd.row)] <= ernn_pkg::SIG_TAB[bin];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= cmd.emit_out || cmd.read_h;
    end

    always_ff @(posedge clk)
    begin
        result_last <= cmd.emit_last;
        if (cmd.read_h)
        begin
            result_kind  <= 1'b1;
            result_index <= 4'(cmd.read_idx);
            result_value <= h_reg[cmd.read_idx];
        end
        else
        begin
            result_kind  <= 1'b0;
            result_index <= 4'(cmd.row);
            result_value <= sat;
        end
    end

endmodule

// ----- rtl/elman_rnn_cell_forward.sv -----
// ============================================================================
// elman_rnn_cell_forward
// Elman recurrent cell forward pass in Q4.12 with a sigmoid hidden layer.
// ============================================================================
// An item is taken when start is high and busy is low. Weight loads, input
// elements without elem_last and hidden clears finish in the accepting cycle.
// An input element with elem_last runs one step: each of the OUT_SIZE output
// rows and then each of the HID_SIZE hidden rows uses one shared
// multiply-accumulate unit over all IN_SIZE+HID_SIZE columns, then drains
// the pipeline and finishes in S_DRN1, S_DRN2 and S_FIN. Output rows are
// emitted one per row as they finish; the hidden update is silent.
// A read of the hidden state emits one item per cycle for the first HID_EMIT
// hidden entries; no new item is taken until the last has been issued.
// Each result is valid for one cycle on result_valid;
// the receiver cannot stall. Reset clears the hidden state and control;
// weight memories and the input buffer hold no defined value until written.
// ============================================================================
module elman_rnn_cell_forward (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [2:0]         weight_group,
    input  logic [3:0]         row,
    input  logic [3:0]         col,
    input  logic signed [15:0] value,
    input  logic               elem_last,
    output logic               result_valid,
    output logic               result_kind,
    output logic [3:0]         result_index,
    output logic signed [15:0] result_value,
    output logic               result_last
);

    ernn_pkg::ernn_cmd_t cmd;
    logic accept;

    assign accept = start && !busy;

    ernn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .req_type  (req_type),
        .elem_last (elem_last),
        .busy      (busy),
        .cmd       (cmd)
    );

    ernn_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_en      (accept),
        .req_type     (req_type),
        .weight_group (weight_group),
        .row          (row),
        .col          (col),
        .value        (value),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .result_index (result_index),
        .result_value (result_value),
        .result_last  (result_last)
    );

endmodule
